### hdl/multi_led_counted_blinker_top_macros.svh
// Assertion macros shared by the LED blinker RTL.
// No dependencies; the files that check their own logic include this header.
`ifndef MULTI_LED_COUNTED_BLINKER_TOP_MACROS_SVH
`define MULTI_LED_COUNTED_BLINKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MLCB_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MLCB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mlcb_pkg.sv
// Shared types and constants for the counted LED blinker.
// No dependencies; used by every module in hdl.
package mlcb_pkg;

   localparam int KIND_W       = 2;
   localparam int MASK_W       = 5;
   localparam int CNT_W        = 8;
   localparam int PER_W        = 8;
   localparam int OUT_W        = 5;
   localparam int NUM_LEDS_DEF = 5;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BLINK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;

   localparam logic [CNT_W-1:0] BLINK_FOREVER = 8'hFF;
   localparam logic [PER_W-1:0] RESET_PERIOD  = 8'd5;
   localparam logic [PER_W-1:0] PHASE_STEP    = 8'h01;

   // Command as seen by one lane: shared fields plus that lane's select bit.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              sel;
      logic [CNT_W-1:0]  count;
      logic [PER_W-1:0]  period;
      logic              level;
   } lane_cmd_type;

   // Lane state after the request's update.
   typedef struct packed {
      logic level;
      logic active;
   } lane_status_type;

endpackage

### hdl/mlcb_lane.sv
// One LED channel: level, blink count, half-period and phase counter.
// Depends on mlcb_pkg and the assertion macro header.
`include "multi_led_counted_blinker_top_macros.svh"

module mlcb_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  mlcb_pkg::lane_cmd_type    cmd,
   output mlcb_pkg::lane_status_type status
);
   import mlcb_pkg::*;

   logic             level_ff,  level_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PER_W-1:0] period_ff, period_in;
   logic [PER_W-1:0] phase_ff,  phase_in;
   logic [PER_W-1:0] phase_inc;
   logic             active;

   always_comb begin
      level_in  = level_ff;
      count_in  = count_ff;
      period_in = period_ff;
      phase_in  = phase_ff;
      active    = (count_ff != '0) && (period_ff != '0);
      phase_inc = phase_ff + PHASE_STEP;
      case (cmd.kind)
         KIND_TICK: begin
            if (active) begin
               if (phase_inc >= period_ff) begin
                  level_in = ~level_ff;
                  phase_in = '0;
                  // falling back to off ends one blink
                  if (count_ff != BLINK_FOREVER && level_ff)
                     count_in = count_ff - CNT_W'(1);
               end else begin
                  phase_in = phase_inc;
               end
            end
         end
         KIND_BLINK: begin
            if (cmd.sel) begin
               level_in  = 1'b0;
               count_in  = cmd.count;
               period_in = cmd.period;
               phase_in  = '0;
            end
         end
         KIND_SET: begin
            if (cmd.sel) begin
               level_in = cmd.level;
               count_in = '0;
            end
         end
         default: ;
      endcase
      status.level  = level_in;
      status.active = (count_in != '0) && (period_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= 1'b0;
         count_ff  <= '0;
         period_ff <= RESET_PERIOD;
         phase_ff  <= '0;
      end else if (accept) begin
         level_ff  <= level_in;
         count_ff  <= count_in;
         period_ff <= period_in;
         phase_ff  <= phase_in;
      end
   end

   // phase never reaches the period, since it is cleared with every new period
   `MLCB_ASSERT(a_phase_below_period, 1'b1, (phase_ff == '0) || (phase_ff < period_ff), "phase counter passed half-period")
   `MLCB_ASSERT_NEXT(a_set_stops_blink, accept && cmd.kind == KIND_SET && cmd.sel, count_ff == '0, "set command left channel blinking")

endmodule

### hdl/mlcb_merge.sv
// Gathers lane status into the response vectors; output register plus skid stage.
// Depends on mlcb_pkg and the assertion macro header.
`include "multi_led_counted_blinker_top_macros.svh"

module mlcb_merge #(
   parameter int NUM_LEDS = mlcb_pkg::NUM_LEDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  mlcb_pkg::lane_status_type   status [NUM_LEDS],
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mlcb_pkg::OUT_W-1:0]  rsp_led_on,
   output logic [mlcb_pkg::OUT_W-1:0]  rsp_blinking
);
   import mlcb_pkg::*;

   logic [OUT_W-1:0] on_vec;
   logic [OUT_W-1:0] blink_vec;
   logic             out_valid_ff;
   logic [OUT_W-1:0] out_on_ff, out_blink_ff;
   logic             skid_valid_ff;
   logic [OUT_W-1:0] skid_on_ff, skid_blink_ff;
   logic             out_take;

   // bits past NUM_LEDS read as zero; channels past the response width are not reported
   for (genvar b = 0; b < OUT_W; b++) begin : g_bit
      if (b < NUM_LEDS) begin : g_lane
         assign on_vec[b]    = status[b].level;
         assign blink_vec[b] = status[b].active;
      end else begin : g_zero
         assign on_vec[b]    = 1'b0;
         assign blink_vec[b] = 1'b0;
      end
   end

   assign out_take     = out_valid_ff && !rsp_stall;
   assign req_stall    = skid_valid_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_led_on   = out_on_ff;
   assign rsp_blinking = out_blink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
            out_on_ff    <= on_vec;
            out_blink_ff <= blink_vec;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_on_ff    <= on_vec;
            skid_blink_ff <= blink_vec;
         end
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_on_ff     <= skid_on_ff;
            out_blink_ff  <= skid_blink_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   `MLCB_ASSERT(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid holds a request with output empty")
   `MLCB_ASSERT_NEXT(a_stalled_fill_skid, accept && out_valid_ff && rsp_stall, skid_valid_ff, "request lost while output stalled")

endmodule

### hdl/multi_led_counted_blinker_top.sv
// Counted LED blinker, top level: NUM_LEDS channel lanes and an output merge stage.
// A request's response is registered in the output register, or in the skid stage while rsp_stall holds the output.
// Throughput: one request per cycle while req_stall is low; each lane updates its channel at the edge of acceptance.
// Input stalls only when the output register and the skid stage are both full.
// Reset (synchronous, active high): all LEDs off, counts zero, half-periods five.
// Depends on mlcb_pkg, mlcb_lane and mlcb_merge.
module multi_led_counted_blinker_top #(
   parameter int NUM_LEDS = mlcb_pkg::NUM_LEDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mlcb_pkg::KIND_W-1:0] req_kind,
   input  logic [mlcb_pkg::MASK_W-1:0] req_led_mask,
   input  logic [mlcb_pkg::CNT_W-1:0]  req_blink_count,
   input  logic [mlcb_pkg::PER_W-1:0]  req_blink_period,
   input  logic                        req_level,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mlcb_pkg::OUT_W-1:0]  rsp_led_on,
   output logic [mlcb_pkg::OUT_W-1:0]  rsp_blinking
);
   import mlcb_pkg::*;

   logic            req_accept;
   lane_cmd_type    lane_cmd    [NUM_LEDS];
   lane_status_type lane_status [NUM_LEDS];

   // A request updates every lane at the edge where it is taken.
   assign req_accept = req_valid && !req_stall;

   // Each lane sees the shared command fields plus its own mask bit;
   // lanes beyond the mask width are never selected and only tick.
   for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
      if (i < MASK_W) begin : g_sel
         assign lane_cmd[i].sel = req_led_mask[i];
      end else begin : g_nosel
         assign lane_cmd[i].sel = 1'b0;
      end
      assign lane_cmd[i].kind   = req_kind;
      assign lane_cmd[i].count  = req_blink_count;
      assign lane_cmd[i].period = req_blink_period;
      assign lane_cmd[i].level  = req_level;

      mlcb_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (req_accept),
         .cmd    (lane_cmd[i]),
         .status (lane_status[i])
      );
   end

   // Merge lane results into the response and buffer them against rsp_stall.
   mlcb_merge #(
      .NUM_LEDS (NUM_LEDS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .status       (lane_status),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_led_on   (rsp_led_on),
      .rsp_blinking (rsp_blinking)
   );

endmodule
